// ===== design/bilinear_upsample_2x_assert.svh =====
// assertion macros for the bilinear 2x upsampler
// expects clk and rst_n in the scope of every use
`ifndef BILINEAR_UPSAMPLE_2X_ASSERT_SVH
`define BILINEAR_UPSAMPLE_2X_ASSERT_SVH
`ifndef SYNTHESIS
`define BUP2X_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BUP2X_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BUP2X_ASSERT_SAME(lbl, ante, cons, msg)
`define BUP2X_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/bup2x_pkg.sv =====
// shared constants and types for the bilinear 2x upsampler
// no dependencies
package bup2x_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int COORD_BITS     = 12;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_IN_USE  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_IN_USE = CFG_INDEX_BITS'(1);

    localparam logic [CFG_DATA_BITS-1:0] SIZE_RESET = CFG_DATA_BITS'(64);

    // position of a tile group and which border tiles follow the main one
    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  right;
        logic                  bottom;
    } tile_pos_t;

endpackage

// ===== design/bup2x_if.sv =====
// channel interfaces of the bilinear 2x upsampler: sample input, result output, config
// depends on bup2x_pkg
interface bup2x_in_if #(
    parameter int SAMPLE_BITS = bup2x_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface bup2x_out_if #(
    parameter int SAMPLE_BITS = bup2x_pkg::SAMPLE_BITS_DEF
) ();
    logic                                  valid;
    logic                                  ready;
    logic [bup2x_pkg::COORD_BITS-1:0]      out_x;
    logic [bup2x_pkg::COORD_BITS-1:0]      out_y;
    logic signed [SAMPLE_BITS+1:0]         out_value;
    logic                                  last_of_item;

    modport source (output valid, output out_x, output out_y, output out_value,
                    output last_of_item, input ready);
    modport sink (input valid, input out_x, input out_y, input out_value,
                  input last_of_item, output ready);
endinterface

interface bup2x_cfg_if ();
    logic                                  valid;
    logic                                  ready;
    logic [bup2x_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [bup2x_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bup2x_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bup2x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word when read and write hit the same entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bup2x_fetch.sv =====
// input side: plane position counters, row-above line memory and the fetch stage
// depends on bup2x_pkg and bup2x_ram
module bup2x_fetch #(
    parameter int MAX_WIDTH   = bup2x_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = bup2x_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLE_BITS = bup2x_pkg::SAMPLE_BITS_DEF,
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [XW-1:0]                 w_last,
    input  logic [YW-1:0]                 h_last,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                          tile_valid,
    input  logic                          tile_ready,
    output bup2x_pkg::tile_pos_t          tile_pos,
    output logic signed [SAMPLE_BITS-1:0] tile_c,
    output logic signed [SAMPLE_BITS-1:0] tile_l,
    output logic signed [SAMPLE_BITS-1:0] tile_u,
    output logic signed [SAMPLE_BITS-1:0] tile_ul
);

    logic [XW-1:0]                 col_reg;
    logic [YW-1:0]                 row_reg;
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [XW-1:0]                 s1_x_reg;
    logic [YW-1:0]                 s1_y_reg;
    logic                          s1_right_reg;
    logic                          s1_bottom_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] upl_reg;

    logic                          accept;
    logic                          move;
    logic                          last_x;
    logic                          last_y;
    logic [SAMPLE_BITS-1:0]        above_word;
    logic                          x_zero;
    logic                          y_zero;

    assign accept   = in_valid && in_ready;
    assign move     = s1_valid_reg && tile_ready;
    assign in_ready = !s1_valid_reg || tile_ready;
    assign last_x   = (col_reg == w_last);
    assign last_y   = (row_reg == h_last);

    // sample of the row above at this column, read as the new one is written
    bup2x_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (in_sample),
        .re    (accept),
        .raddr (col_reg),
        .rdata (above_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_x)
            begin
                col_reg <= '0;
                row_reg <= last_y ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= in_sample;
            s1_x_reg      <= col_reg;
            s1_y_reg      <= row_reg;
            s1_right_reg  <= last_x;
            s1_bottom_reg <= last_y;
        end
    end

    assign x_zero = (s1_x_reg == '0);
    assign y_zero = (s1_y_reg == '0);

    // read data stays put while the item waits, so neighbours are formed at hand-off
    assign tile_c  = s1_sample_reg;
    assign tile_u  = y_zero ? '0 : $signed(above_word);
    assign tile_l  = x_zero ? '0 : left_reg;
    assign tile_ul = (x_zero || y_zero) ? '0 : upl_reg;

    assign tile_valid      = s1_valid_reg;
    assign tile_pos.px     = bup2x_pkg::COORD_BITS'({s1_x_reg, 1'b0});
    assign tile_pos.py     = bup2x_pkg::COORD_BITS'({s1_y_reg, 1'b0});
    assign tile_pos.right  = s1_right_reg;
    assign tile_pos.bottom = s1_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            upl_reg  <= '0;
        end
        else if (move)
        begin
            left_reg <= s1_sample_reg;
            upl_reg  <= tile_u;
        end
    end

endmodule

// ===== design/bup2x_emit.sv =====
// output side: walks the main and border tiles of one item, one pixel a cycle unless the consumer stalls the output
// depends on bup2x_pkg
module bup2x_emit #(
    parameter int SAMPLE_BITS = bup2x_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  tile_valid,
    output logic                                  tile_ready,
    input  bup2x_pkg::tile_pos_t                  tile_pos,
    input  logic signed [SAMPLE_BITS-1:0]         tile_c,
    input  logic signed [SAMPLE_BITS-1:0]         tile_l,
    input  logic signed [SAMPLE_BITS-1:0]         tile_u,
    input  logic signed [SAMPLE_BITS-1:0]         tile_ul,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bup2x_pkg::COORD_BITS-1:0]      out_x,
    output logic [bup2x_pkg::COORD_BITS-1:0]      out_y,
    output logic signed [SAMPLE_BITS+1:0]         out_value,
    output logic                                  last_of_item
);

    localparam int VW = SAMPLE_BITS + 2;

    localparam logic [1:0] TILE_MAIN   = 2'd0;
    localparam logic [1:0] TILE_RIGHT  = 2'd1;
    localparam logic [1:0] TILE_BOTTOM = 2'd2;
    localparam logic [1:0] TILE_CORNER = 2'd3;

    logic                              s2_valid_reg;
    bup2x_pkg::tile_pos_t              pos_reg;
    logic signed [SAMPLE_BITS-1:0]     c_reg;
    logic signed [SAMPLE_BITS-1:0]     l_reg;
    logic signed [SAMPLE_BITS-1:0]     u_reg;
    logic signed [SAMPLE_BITS-1:0]     ul_reg;
    logic [1:0]                        tile_reg;
    logic [1:0]                        pix_reg;
    logic                              out_valid_reg;
    logic [bup2x_pkg::COORD_BITS-1:0]  out_x_reg;
    logic [bup2x_pkg::COORD_BITS-1:0]  out_y_reg;
    logic signed [VW-1:0]              out_value_reg;
    logic                              last_reg;

    logic [1:0]                        tile_next;
    logic                              has_next;
    logic                              final_pix;
    logic                              step;
    logic                              load;
    logic signed [VW-1:0]              ce;
    logic signed [VW-1:0]              le;
    logic signed [VW-1:0]              ue;
    logic signed [VW-1:0]              ule;
    logic signed [VW-1:0]              sum_cu;
    logic signed [VW-1:0]              sum_cl;
    logic signed [VW-1:0]              sum_all;
    logic signed [VW-1:0]              value;
    logic [1:0]                        xoff;
    logic [1:0]                        yoff;

    // which border tile comes after the current one
    always_comb
    begin
        tile_next = TILE_MAIN;
        has_next  = 1'b0;
        unique case (tile_reg)
            TILE_MAIN:
            begin
                if (pos_reg.right)
                begin
                    tile_next = TILE_RIGHT;
                    has_next  = 1'b1;
                end
                else if (pos_reg.bottom)
                begin
                    tile_next = TILE_BOTTOM;
                    has_next  = 1'b1;
                end
            end
            TILE_RIGHT:
            begin
                if (pos_reg.bottom)
                begin
                    tile_next = TILE_BOTTOM;
                    has_next  = 1'b1;
                end
            end
            TILE_BOTTOM:
            begin
                if (pos_reg.right)
                begin
                    tile_next = TILE_CORNER;
                    has_next  = 1'b1;
                end
            end
            TILE_CORNER:
            begin
                has_next = 1'b0;
            end
            default:
            begin
                has_next = 1'b0;
            end
        endcase
    end

    assign final_pix  = (pix_reg == 2'd3) && !has_next;
    assign step       = s2_valid_reg && (!out_valid_reg || out_ready);
    assign tile_ready = !s2_valid_reg || (step && final_pix);
    assign load       = tile_valid && tile_ready;

    assign ce  = {{2{c_reg[SAMPLE_BITS-1]}}, c_reg};
    assign le  = {{2{l_reg[SAMPLE_BITS-1]}}, l_reg};
    assign ue  = {{2{u_reg[SAMPLE_BITS-1]}}, u_reg};
    assign ule = {{2{ul_reg[SAMPLE_BITS-1]}}, ul_reg};

    assign sum_cu  = ce + ue;
    assign sum_cl  = ce + le;
    assign sum_all = sum_cu + le + ule;

    // values in quarters of an input unit; last column and row are zero
    always_comb
    begin
        value = '0;
        case (tile_reg)
            TILE_MAIN:
            begin
                case (pix_reg)
                    2'd0:    value = sum_all;
                    2'd1:    value = sum_cu <<< 1;
                    2'd2:    value = sum_cl <<< 1;
                    default: value = ce <<< 2;
                endcase
            end
            TILE_RIGHT:
            begin
                case (pix_reg)
                    2'd0:    value = sum_cu;
                    2'd2:    value = ce <<< 1;
                    default: value = '0;
                endcase
            end
            TILE_BOTTOM:
            begin
                case (pix_reg)
                    2'd0:    value = sum_cl;
                    2'd1:    value = ce <<< 1;
                    default: value = '0;
                endcase
            end
            default:
            begin
                value = (pix_reg == 2'd0) ? ce : '0;
            end
        endcase
    end

    assign xoff = {(tile_reg == TILE_RIGHT) || (tile_reg == TILE_CORNER), pix_reg[0]};
    assign yoff = {(tile_reg == TILE_BOTTOM) || (tile_reg == TILE_CORNER), pix_reg[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            tile_reg     <= TILE_MAIN;
            pix_reg      <= 2'd0;
        end
        else if (load)
        begin
            s2_valid_reg <= 1'b1;
            tile_reg     <= TILE_MAIN;
            pix_reg      <= 2'd0;
        end
        else if (step)
        begin
            if (pix_reg == 2'd3)
            begin
                if (has_next)
                begin
                    tile_reg <= tile_next;
                end
                else
                begin
                    s2_valid_reg <= 1'b0;
                end
            end
            pix_reg <= pix_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg <= tile_pos;
            c_reg   <= tile_c;
            l_reg   <= tile_l;
            u_reg   <= tile_u;
            ul_reg  <= tile_ul;
        end
    end

    // output register parts the pixel walk from the consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_x_reg     <= pos_reg.px + bup2x_pkg::COORD_BITS'(xoff);
            out_y_reg     <= pos_reg.py + bup2x_pkg::COORD_BITS'(yoff);
            out_value_reg <= value;
            last_reg      <= final_pix;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_value    = out_value_reg;
    assign last_of_item = last_reg;

endmodule

// ===== design/bilinear_upsample_2x.sv =====
// Bilinear 2x upsampler. Takes one plane of signed samples in raster order and
// gives the (2W+2) x (2H+2) output pixels, each word carrying its coordinates, the
// value in quarters of an input unit and a flag on the last pixel of the sample.
// An interior sample gives 4 output words, one a cycle as the output port allows; a
// sample in the last column or the last row gives 8, the last sample of the plane 16.
// The row-above line memory is read and written once per sample. The first word of
// a sample passes the fetch stage, the emit stage and the output register. Writing
// either size register restarts the plane; sizes of 0 count as 1, sizes above the
// maximum as the maximum. Write registers only while the block is idle.
// depends on bup2x_pkg, bup2x_if, bup2x_fetch, bup2x_emit, bup2x_ram
`include "bilinear_upsample_2x_assert.svh"

module bilinear_upsample_2x #(
    parameter int MAX_WIDTH   = bup2x_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = bup2x_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLE_BITS = bup2x_pkg::SAMPLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bup2x_in_if.sink    samples,
    bup2x_out_if.source results,
    bup2x_cfg_if.sink   cfg
);

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [bup2x_pkg::CFG_DATA_BITS-1:0] width_reg;
    logic [bup2x_pkg::CFG_DATA_BITS-1:0] height_reg;

    logic                          cfg_write;
    logic                          restart;
    logic [XW-1:0]                 w_last;
    logic [YW-1:0]                 h_last;
    logic                          tile_valid;
    logic                          tile_ready;
    bup2x_pkg::tile_pos_t          tile_pos;
    logic signed [SAMPLE_BITS-1:0] tile_c;
    logic signed [SAMPLE_BITS-1:0] tile_l;
    logic signed [SAMPLE_BITS-1:0] tile_u;
    logic signed [SAMPLE_BITS-1:0] tile_ul;
    logic                          tile_wait;
    logic                          last_word;
    logic                          odd_pixel;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign restart   = cfg_write && ((cfg.index == bup2x_pkg::REG_WIDTH_IN_USE) ||
                                     (cfg.index == bup2x_pkg::REG_HEIGHT_IN_USE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bup2x_pkg::SIZE_RESET;
            height_reg <= bup2x_pkg::SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                bup2x_pkg::REG_WIDTH_IN_USE:  width_reg  <= cfg.data;
                bup2x_pkg::REG_HEIGHT_IN_USE: height_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // last column and row index after clamping the sizes
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_last = '0;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_last = XW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = XW'(width_reg - 1'b1);
        end

        if (height_reg == '0)
        begin
            h_last = '0;
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            h_last = YW'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = YW'(height_reg - 1'b1);
        end
    end

    bup2x_fetch #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .w_last     (w_last),
        .h_last     (h_last),
        .in_valid   (samples.valid),
        .in_ready   (samples.ready),
        .in_sample  (samples.sample),
        .tile_valid (tile_valid),
        .tile_ready (tile_ready),
        .tile_pos   (tile_pos),
        .tile_c     (tile_c),
        .tile_l     (tile_l),
        .tile_u     (tile_u),
        .tile_ul    (tile_ul)
    );

    bup2x_emit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .tile_valid   (tile_valid),
        .tile_ready   (tile_ready),
        .tile_pos     (tile_pos),
        .tile_c       (tile_c),
        .tile_l       (tile_l),
        .tile_u       (tile_u),
        .tile_ul      (tile_ul),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .out_x        (results.out_x),
        .out_y        (results.out_y),
        .out_value    (results.out_value),
        .last_of_item (results.last_of_item)
    );

    assign tile_wait = tile_valid && !tile_ready;
    assign last_word = results.valid && results.last_of_item;
    assign odd_pixel = results.out_x[0] && results.out_y[0];

    // a taken sample is in the fetch stage on the next cycle
    `BUP2X_ASSERT_NEXT(a_fetch_loaded, samples.valid && samples.ready, tile_valid, "sample lost")
    // a tile held back by the pixel walk keeps its position
    `BUP2X_ASSERT_NEXT(a_tile_held, tile_wait, tile_valid && $stable(tile_pos), "tile changed")
    // every tile ends on its odd-odd pixel, so the last word of a sample does too
    `BUP2X_ASSERT_SAME(a_last_odd, last_word, odd_pixel, "last word not at odd-odd pixel")

endmodule

// ===== sim/bilinear_upsample_2x_tb.sv =====
// testbench for the bilinear 2x upsampler: directed table, then random planes of many sizes
// predicts every output word in-house and checks each one in order
// depends on bup2x_pkg, bup2x_if and bilinear_upsample_2x
module bilinear_upsample_2x_tb;

    localparam int MAX_W          = bup2x_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H          = bup2x_pkg::MAX_HEIGHT_DEF;
    localparam int COORD_BITS     = bup2x_pkg::COORD_BITS;
    localparam int CFG_INDEX_BITS = bup2x_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = bup2x_pkg::CFG_DATA_BITS;
    localparam int RAND_ITEMS     = 260;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_WAIT     = 20;

    // an index the block does not decode
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = CFG_INDEX_BITS'(255);

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        int                        smp;
        bit                        typed;
        int                        tx;
        int                        ty;
        int                        v0;
        int                        v1;
        int                        v2;
        int                        v3;
    } stim_row_t;

    typedef struct {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic signed [17:0]    value;
        logic                  last_flag;
    } pixel_t;

    // typed rows give the main tile only: base coordinates and the four values in quarters
    stim_row_t dir_tab [26] = '{
        '{ROW_SAMPLE, 8'd0, 11'd0, 32767, 1'b1, 0, 0, 32767, 65534, 65534, 131068},
        '{ROW_SAMPLE, 8'd0, 11'd0, -32768, 1'b1, 2, 0, -1, -65536, -2, -131072},
        '{ROW_SAMPLE, 8'd0, 11'd0, 0, 1'b1, 4, 0, -32768, 0, -65536, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, -1, 1'b1, 6, 0, -1, -2, -2, -4},
        '{ROW_CFG, REG_UNUSED, 11'h7FF, 0, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, 5, 1'b1, 8, 0, 4, 10, 8, 20},
        '{ROW_CFG, bup2x_pkg::REG_WIDTH_IN_USE, 11'd0, 0, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bup2x_pkg::REG_HEIGHT_IN_USE, 11'd0, 0, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, 32767, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, -32768, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bup2x_pkg::REG_WIDTH_IN_USE, 11'd2, 0, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bup2x_pkg::REG_HEIGHT_IN_USE, 11'd2, 0, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, 32767, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, -32768, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, -32768, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, 32767, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, 100, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bup2x_pkg::REG_WIDTH_IN_USE, 11'h7FF, 0, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bup2x_pkg::REG_HEIGHT_IN_USE, 11'd1, 0, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, 7, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, -7, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bup2x_pkg::REG_HEIGHT_IN_USE, 11'h7FF, 0, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bup2x_pkg::REG_WIDTH_IN_USE, 11'd3, 0, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, 1234, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, -4321, 1'b0, 0, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE, 8'd0, 11'd0, 32767, 1'b0, 0, 0, 0, 0, 0, 0}
    };

    logic clk;
    logic rst_n;

    bup2x_in_if  #(.SAMPLE_BITS(bup2x_pkg::SAMPLE_BITS_DEF)) samples_if ();
    bup2x_out_if #(.SAMPLE_BITS(bup2x_pkg::SAMPLE_BITS_DEF)) results_if ();
    bup2x_cfg_if                                             cfg_if ();

    bilinear_upsample_2x u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // predictor state
    int                       row_above [MAX_W];
    int                       left_s;
    int                       upleft_s;
    int                       col_pos;
    int                       row_pos;
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;

    pixel_t tile_words [$];
    pixel_t pixel_q [$];

    int errors = 0;
    int quiet  = 0;
    bit steady = 1'b0;
    bit in_up  = 1'b0;
    int ready_run = 0;
    bit ready_lvl = 1'b0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int clamp_size(input logic [CFG_DATA_BITS-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic signed [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'sh7FFF;
        if (r < 16)
            return 16'sh8000;
        if (r < 20)
            return 16'sh0000;
        if (r < 24)
            return 16'shFFFF;
        return 16'($urandom);
    endfunction

    function automatic void add_word(input int px, input int py, input int v);
        pixel_t p;
        p.px        = COORD_BITS'(px);
        p.py        = COORD_BITS'(py);
        p.value     = 18'(v);
        p.last_flag = 1'b0;
        tile_words.push_back(p);
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] val);
        if (idx == bup2x_pkg::REG_WIDTH_IN_USE || idx == bup2x_pkg::REG_HEIGHT_IN_USE)
        begin
            if (idx == bup2x_pkg::REG_WIDTH_IN_USE)
                width_reg = val;
            else
                height_reg = val;
            col_pos  = 0;
            row_pos  = 0;
            left_s   = 0;
            upleft_s = 0;
        end
    endfunction

    // words one sample causes, left in tile_words; state moves on to the next position
    function automatic void upsample_sample(input logic signed [15:0] s);
        int w, h, x, y, c, l, u, ul, px, py;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        x = (col_pos >= w) ? 0 : col_pos;
        y = (row_pos >= h) ? 0 : row_pos;
        c  = s;
        l  = (x == 0) ? 0 : left_s;
        u  = (y == 0) ? 0 : row_above[x];
        ul = (x == 0 || y == 0) ? 0 : upleft_s;
        px = 2 * x;
        py = 2 * y;
        tile_words.delete();
        add_word(px, py, c + l + u + ul);
        add_word(px + 1, py, 2 * (c + u));
        add_word(px, py + 1, 2 * (c + l));
        add_word(px + 1, py + 1, 4 * c);
        if (x == w - 1)
        begin
            add_word(px + 2, py, c + u);
            add_word(px + 3, py, 0);
            add_word(px + 2, py + 1, 2 * c);
            add_word(px + 3, py + 1, 0);
        end
        if (y == h - 1)
        begin
            add_word(px, py + 2, c + l);
            add_word(px + 1, py + 2, 2 * c);
            add_word(px, py + 3, 0);
            add_word(px + 1, py + 3, 0);
        end
        if (x == w - 1 && y == h - 1)
        begin
            add_word(px + 2, py + 2, c);
            add_word(px + 3, py + 2, 0);
            add_word(px + 2, py + 3, 0);
            add_word(px + 3, py + 3, 0);
        end
        tile_words[tile_words.size() - 1].last_flag = 1'b1;
        upleft_s     = u;
        left_s       = c;
        row_above[x] = c;
        x++;
        if (x >= w)
        begin
            x        = 0;
            left_s   = 0;
            upleft_s = 0;
            y++;
            if (y >= h)
                y = 0;
        end
        col_pos = x;
        row_pos = y;
    endfunction

    // row < 0 or an untyped row: expectations come from the predictor, else typed from the table row
    task automatic send_sample(input logic signed [15:0] s, input int row);
        int     gap;
        pixel_t p;
        gap = pick_gap();
        if (gap > 0 && in_up)
        begin
            samples_if.valid <= 1'b0;
            in_up = 1'b0;
        end
        repeat (gap) @(posedge clk);
        samples_if.valid  <= 1'b1;
        samples_if.sample <= s;
        in_up = 1'b1;
        do @(posedge clk); while (!samples_if.ready);
        upsample_sample(s);
        if (row >= 0 && dir_tab[row].typed)
        begin
            p = '{COORD_BITS'(dir_tab[row].tx), COORD_BITS'(dir_tab[row].ty),
                  18'(dir_tab[row].v0), 1'b0};
            pixel_q.push_back(p);
            p = '{COORD_BITS'(dir_tab[row].tx + 1), COORD_BITS'(dir_tab[row].ty),
                  18'(dir_tab[row].v1), 1'b0};
            pixel_q.push_back(p);
            p = '{COORD_BITS'(dir_tab[row].tx), COORD_BITS'(dir_tab[row].ty + 1),
                  18'(dir_tab[row].v2), 1'b0};
            pixel_q.push_back(p);
            p = '{COORD_BITS'(dir_tab[row].tx + 1), COORD_BITS'(dir_tab[row].ty + 1),
                  18'(dir_tab[row].v3), 1'b1};
            pixel_q.push_back(p);
        end
        else
        begin
            foreach (tile_words[i])
                pixel_q.push_back(tile_words[i]);
        end
    endtask

    task automatic wait_idle();
        if (in_up)
        begin
            samples_if.valid <= 1'b0;
            in_up = 1'b0;
        end
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        apply_register(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic compare_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
            errors++;
        end
    endtask

    // result side stalls
    always @(posedge clk)
    begin
        if (ready_run > 0)
            ready_run--;
        else if (ready_lvl && !steady)
        begin
            ready_lvl = 1'b0;
            ready_run = pick_gap();
        end
        else
        begin
            ready_lvl = 1'b1;
            ready_run = $urandom_range(0, 20);
        end
        results_if.ready <= ready_lvl;
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pixel_q.size() == 0)
            begin
                $display("%0t: word expected none got x=%0d y=%0d value=%0d last=%0d", $time,
                         results_if.out_x, results_if.out_y, results_if.out_value,
                         results_if.last_of_item);
                errors++;
            end
            else
            begin
                want = pixel_q.pop_front();
                compare_field("out_x", int'(want.px), int'(results_if.out_x));
                compare_field("out_y", int'(want.py), int'(results_if.out_y));
                compare_field("out_value", int'(want.value), int'(results_if.out_value));
                compare_field("last_of_item", int'(want.last_flag),
                              int'(results_if.last_of_item));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        while (quiet < QUIET_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int rand_items;
        int w, h, n, eff;
        bit width_first;
        int pick;

        rst_n             <= 1'b0;
        samples_if.valid  <= 1'b0;
        samples_if.sample <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;

        foreach (row_above[i])
            row_above[i] = 0;
        left_s     = 0;
        upleft_s   = 0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = bup2x_pkg::SIZE_RESET;
        height_reg = bup2x_pkg::SIZE_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            else
                send_sample(16'(dir_tab[i].smp), i);
        end

        // random planes, mostly small, whole planes or cut short by a register write
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            w = (pick < 5) ? 0 : (pick < 80) ? $urandom_range(1, 6) : $urandom_range(7, 24);
            pick = $urandom_range(0, 99);
            h = (pick < 5) ? 0 : (pick < 85) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_INDEX_BITS'($urandom_range(2, 255)), CFG_DATA_BITS'($urandom));
            width_first = $urandom_range(0, 1);
            pick = $urandom_range(0, 3);
            if (width_first && pick != 0)
                write_reg(bup2x_pkg::REG_WIDTH_IN_USE, CFG_DATA_BITS'(w));
            if (pick != 1)
                write_reg(bup2x_pkg::REG_HEIGHT_IN_USE, CFG_DATA_BITS'(h));
            if (!width_first && pick != 0)
                write_reg(bup2x_pkg::REG_WIDTH_IN_USE, CFG_DATA_BITS'(w));
            if (pick == 0)
                write_reg(bup2x_pkg::REG_WIDTH_IN_USE, CFG_DATA_BITS'(w));
            eff = clamp_size(width_reg, MAX_W) * clamp_size(height_reg, MAX_H);
            if ($urandom_range(0, 9) < 7)
                n = eff * $urandom_range(1, 2);
            else
                n = $urandom_range(1, 2 * eff);
            if (n > 150)
                n = 150;
            if (n > RAND_ITEMS - rand_items)
                n = RAND_ITEMS - rand_items;
            repeat (n)
            begin
                send_sample(rand_sample(), -1);
                rand_items++;
            end
        end

        // a few samples at the widest plane, then a few of the tallest
        steady = 1'b0;
        write_reg(bup2x_pkg::REG_WIDTH_IN_USE, CFG_DATA_BITS'(MAX_W));
        write_reg(bup2x_pkg::REG_HEIGHT_IN_USE, CFG_DATA_BITS'(1));
        repeat (24)
            send_sample(rand_sample(), -1);
        write_reg(bup2x_pkg::REG_WIDTH_IN_USE, CFG_DATA_BITS'(1));
        write_reg(bup2x_pkg::REG_HEIGHT_IN_USE, CFG_DATA_BITS'(MAX_H));
        repeat (24)
            send_sample(rand_sample(), -1);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
